[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// item field widths, item kind codes, control characters, register map
// ----------------------------------------------------------------------------
package tcw_pkg;

    // item field widths
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;

    // item kind codes
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // control characters that start a new line
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

    // register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTR = 2'd0;
    localparam logic [CHAR_W-1:0]  ATTR_RESET     = 8'd7;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_FILL = 5'b00100,
        S_READ = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

endpackage
`default_nettype wire

[rtl/tcw_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_in_if: request channel of the text console writer
// valid/ready handshake with the put, read and clear request fields
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::KIND_W-1:0]   kind;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::ROW_W-1:0]    read_row;
    logic [tcw_pkg::COL_W-1:0]    read_col;

    modport source (output valid, kind, char_code, read_row, read_col, input ready);
    modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface
`default_nettype wire

[rtl/tcw_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_out_if: result channel of the text console writer
// valid/ready handshake with the reported cell and the cursor position
// ----------------------------------------------------------------------------
interface tcw_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::CHAR_W-1:0]   cell_attr;
    logic [tcw_pkg::COL_W-1:0]    cursor_col;
    logic [tcw_pkg::ROW_W-1:0]    cursor_row;

    modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row,
                    output ready);
endinterface
`default_nettype wire

[rtl/text_console_writer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// sequence: an accepted item runs through S_EXEC, S_READ and S_RESP before its
//   result is registered; a write into a row untouched since reset, clear or
//   scroll first zeroes that row in S_FILL; items are taken only in S_IDLE, one
//   at a time; the single memory port and row/address unit do one access per cycle
// reset: cursor home, attribute 7, all row valid bits cleared so the whole
//   screen reads as zero at once; no clearing pass over the memory
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console screen buffer with scroll
// put / read / clear items, circular row buffer with lazy row zeroing
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int NUM_COLS = 80,
    parameter int NUM_ROWS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // item channels
    tcw_in_if.sink                             in_ch,
    tcw_out_if.source                          out_ch
);

    // widths derived from the screen size
    localparam int CW    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CELLS = NUM_ROWS * NUM_COLS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(NUM_ROWS);
    localparam logic [AW-1:0] COLS_A   = AW'(NUM_COLS);

    // screen memory: physical row p, column c lives at p*NUM_COLS + c
    logic [tcw_pkg::CELL_W-1:0] screen_mem [CELLS];

    // sequencer and item registers
    tcw_pkg::state_t              state_reg, state_next;
    logic [tcw_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic [tcw_pkg::ROW_W-1:0]    rrow_reg, rrow_next;
    logic [tcw_pkg::COL_W-1:0]    rcol_reg, rcol_next;

    // cursor, scroll offset and per-row valid bits
    logic [CW-1:0]                cur_col_reg, cur_col_next;
    logic [RW-1:0]                cur_row_reg, cur_row_next;
    logic [RW-1:0]                top_reg, top_next;
    logic [NUM_ROWS-1:0]          row_valid_reg, row_valid_next;
    logic [CW-1:0]                fill_col_reg, fill_col_next;

    // configuration
    logic [tcw_pkg::CHAR_W-1:0]   attr_reg, attr_next;

    // read path
    logic                         rd_hit_reg, rd_hit_next;
    logic [tcw_pkg::CELL_W-1:0]   mem_q_reg;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [tcw_pkg::CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [tcw_pkg::CHAR_W-1:0]   out_attr_reg, out_attr_next;
    logic [tcw_pkg::COL_W-1:0]    out_col_reg, out_col_next;
    logic [tcw_pkg::ROW_W-1:0]    out_row_reg, out_row_next;

    // shared address unit
    logic [RW-1:0]                au_row;
    logic [CW-1:0]                au_col;
    logic [RW:0]                  au_sum;
    logic [RW-1:0]                au_phys;
    logic [AW-1:0]                au_addr;
    logic                         au_valid;

    // memory access controls
    logic                         mem_we;
    logic                         mem_re;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [tcw_pkg::CELL_W-1:0]   cell_wdata;

    logic                         in_accept;
    logic                         rd_in_range;
    logic                         cfg_write;
    logic                         do_advance;
    logic                         do_newline;

    assign in_ch.ready = (state_reg == tcw_pkg::S_IDLE) &&
                         (!out_valid_reg || out_ch.ready);
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cell_char  = out_char_reg;
    assign out_ch.cell_attr  = out_attr_reg;
    assign out_ch.cursor_col = out_col_reg;
    assign out_ch.cursor_row = out_row_reg;

    // apb: always ready, single attribute register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == tcw_pkg::ADDR_TEXT_ATTR);
    assign prdata    = (paddr == tcw_pkg::ADDR_TEXT_ATTR) ?
                       {{(tcw_pkg::PDATA_W - tcw_pkg::CHAR_W){1'b0}}, attr_reg} : '0;
    assign attr_next = cfg_write ? pwdata[tcw_pkg::CHAR_W-1:0] : attr_reg;

    assign cell_wdata  = {attr_reg, char_reg};
    assign rd_in_range = (32'(rrow_reg) < NUM_ROWS) && (32'(rcol_reg) < NUM_COLS);

    // address unit operand select: read coordinates, fill sweep, or cursor
    always_comb
    begin
        case (state_reg)
            tcw_pkg::S_READ:
            begin
                au_row = rd_in_range ? RW'(rrow_reg) : '0;
                au_col = rd_in_range ? CW'(rcol_reg) : '0;
            end
            tcw_pkg::S_FILL:
            begin
                au_row = cur_row_reg;
                au_col = fill_col_reg;
            end
            default:
            begin
                au_row = cur_row_reg;
                au_col = cur_col_reg;
            end
        endcase
    end

    // logical row to physical row (circular by top_reg), then cell address
    assign au_sum   = {1'b0, au_row} + {1'b0, top_reg};
    assign au_phys  = (au_sum >= ROWS_X) ? RW'(au_sum - ROWS_X) : au_sum[RW-1:0];
    assign au_addr  = AW'(au_phys) * COLS_A + AW'(au_col);
    assign au_valid = row_valid_reg[au_phys];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        rrow_next      = rrow_reg;
        rcol_next      = rcol_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        fill_col_next  = fill_col_reg;
        rd_hit_next    = rd_hit_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = cell_wdata;
        do_advance     = 1'b0;
        do_newline     = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcw_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = in_ch.kind;
                    char_next  = in_ch.char_code;
                    rrow_next  = in_ch.read_row;
                    rcol_next  = in_ch.read_col;
                    state_next = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC:
            begin
                state_next = tcw_pkg::S_READ;
                case (kind_reg)
                    tcw_pkg::KIND_PUT:
                    begin
                        if (char_reg == tcw_pkg::CH_LF || char_reg == tcw_pkg::CH_CR)
                        begin
                            do_newline = 1'b1;
                        end
                        else if (au_valid)
                        begin
                            mem_we     = 1'b1;
                            do_advance = 1'b1;
                        end
                        else
                        begin
                            // row not in use yet: zero it, dropping the char in on the way
                            fill_col_next = '0;
                            state_next    = tcw_pkg::S_FILL;
                        end
                    end
                    tcw_pkg::KIND_CLEAR:
                    begin
                        row_valid_next = '0;
                        cur_col_next   = '0;
                        cur_row_next   = '0;
                        top_next       = '0;
                    end
                    default:
                    begin
                        // read and unused kind change nothing
                    end
                endcase
            end
            tcw_pkg::S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (fill_col_reg == cur_col_reg) ? cell_wdata : '0;
                if (fill_col_reg == LAST_COL)
                begin
                    row_valid_next[au_phys] = 1'b1;
                    do_advance              = 1'b1;
                    state_next              = tcw_pkg::S_READ;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end
            tcw_pkg::S_READ:
            begin
                mem_re      = 1'b1;
                rd_hit_next = rd_in_range && au_valid;
                state_next  = tcw_pkg::S_RESP;
            end
            tcw_pkg::S_RESP:
            begin
                out_valid_next = 1'b1;
                out_char_next  = rd_hit_reg ? mem_q_reg[7:0] : '0;
                out_attr_next  = rd_hit_reg ? mem_q_reg[15:8] : '0;
                out_col_next   = tcw_pkg::COL_W'(cur_col_reg);
                out_row_next   = tcw_pkg::ROW_W'(cur_row_reg);
                state_next     = tcw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
        endcase

        // column advance wraps into a newline at the last column
        if (do_advance)
        begin
            if (cur_col_reg == LAST_COL)
            begin
                do_newline = 1'b1;
            end
            else
            begin
                cur_col_next = cur_col_reg + 1'b1;
            end
        end

        // newline from the last row scrolls: the old top row becomes the
        // new, empty bottom row
        if (do_newline)
        begin
            cur_col_next = '0;
            if (cur_row_reg == LAST_ROW)
            begin
                row_valid_next[top_reg] = 1'b0;
                top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
            end
            else
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::S_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        char_reg     <= char_next;
        rrow_reg     <= rrow_next;
        rcol_reg     <= rcol_next;
        fill_col_reg <= fill_col_next;
        rd_hit_reg   <= rd_hit_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
    end

    // screen memory, one access per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[au_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= screen_mem[au_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/tcw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// result hold, input blocking, early result and cursor range, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int NUM_COLS = 80
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [tcw_pkg::COL_W-1:0]    cursor_col
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // no new item while an untaken result is pending
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted while result stalled");

    // no result right after an item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result showed up too early");

    // reported cursor column stays on screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_col) < NUM_COLS)
        else $error("cursor column off screen");

endmodule

bind text_console_writer_core tcw_checker #(
    .NUM_COLS (NUM_COLS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cursor_col (out_ch.cursor_col)
);
`default_nettype wire
